// File: rtl/arpc_pkg.sv
// shared constants, types and helpers for the arp cache
package arpc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SLOT_W  = 4;
    localparam int CMD_W   = 2;
    localparam int ENTRY_W = IP_W + MAC_W;

    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = CMD_W;
    localparam int OUT_FIELD_W = 1 + MAC_W + SLOT_W + 1;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
    } t_res;

    typedef struct packed {
        logic start;
        logic res_ready;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = (IDX_W + SLOT_W)'(idx);
        return ext[SLOT_W-1:0];
    endfunction

endpackage

// File: rtl/arpc_ram.sv
// generic single-port-write ram with registered read
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/arpc_engine.sv
// scan and write-back sequencer over the cache entry memory
module arpc_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpc_pkg::t_eng_ctl  i_ctl,
    input  arpc_pkg::t_req      i_req,
    output arpc_pkg::t_eng_stat o_stat,
    output arpc_pkg::t_res      o_res
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    localparam logic [arpc_pkg::CNT_W-1:0] CNT_END = arpc_pkg::CNT_W'(arpc_pkg::ENTRIES);
    localparam logic [arpc_pkg::IDX_W-1:0] IDX_LAST =
        arpc_pkg::IDX_W'(arpc_pkg::ENTRIES - 1);

    t_state                             r_state, n_state;
    logic [arpc_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic                               r_chk, n_chk;
    logic [arpc_pkg::ENTRIES-1:0]       r_valid, n_valid;
    logic [arpc_pkg::IDX_W-1:0]         r_ptr, n_ptr;
    logic                               r_found, n_found;
    logic                               r_empty, n_empty;

    arpc_pkg::t_req                     r_req, n_req;
    logic [arpc_pkg::IDX_W-1:0]         r_chk_idx, n_chk_idx;
    logic [arpc_pkg::IDX_W-1:0]         r_idx, n_idx;
    logic [arpc_pkg::IDX_W-1:0]         r_empty_idx, n_empty_idx;
    logic [arpc_pkg::MAC_W-1:0]         r_hit_mac, n_hit_mac;
    arpc_pkg::t_res                     r_res, n_res;

    logic                               ram_we;
    logic [arpc_pkg::IDX_W-1:0]         ram_waddr;
    logic [arpc_pkg::ENTRY_W-1:0]       ram_wdata;
    logic [arpc_pkg::ENTRY_W-1:0]       ram_rdata;
    logic [arpc_pkg::IP_W-1:0]          rd_ip;
    logic [arpc_pkg::MAC_W-1:0]         rd_mac;
    logic                               match;

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (arpc_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cnt[arpc_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_ip  = ram_rdata[arpc_pkg::IP_W-1:0];
    assign rd_mac = ram_rdata[arpc_pkg::ENTRY_W-1:arpc_pkg::IP_W];
    assign match  = r_chk && r_valid[r_chk_idx] && (rd_ip == r_req.ip);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_chk       = r_chk;
        n_valid     = r_valid;
        n_ptr       = r_ptr;
        n_found     = r_found;
        n_empty     = r_empty;
        n_req       = r_req;
        n_chk_idx   = r_chk_idx;
        n_idx       = r_idx;
        n_empty_idx = r_empty_idx;
        n_hit_mac   = r_hit_mac;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = {r_req.mac, r_req.ip};

        case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_req   = i_req;
                    n_cnt   = '0;
                    n_chk   = 1'b0;
                    n_found = 1'b0;
                    n_empty = 1'b0;
                    if (i_req.cmd == arpc_pkg::CMD_CLEAR) begin
                        n_valid = '0;
                        n_ptr   = '0;
                        n_res   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_chk     = (r_cnt < CNT_END);
                n_chk_idx = r_cnt[arpc_pkg::IDX_W-1:0];
                if (r_cnt < CNT_END) begin
                    n_cnt = r_cnt + arpc_pkg::CNT_W'(1);
                end
                if (match && !r_found) begin
                    n_found   = 1'b1;
                    n_idx     = r_chk_idx;
                    n_hit_mac = rd_mac;
                end
                if (match && r_req.cmd == arpc_pkg::CMD_DELETE) begin
                    n_valid[r_chk_idx] = 1'b0;
                end
                if (r_chk && !r_valid[r_chk_idx]) begin
                    n_empty     = 1'b1;
                    n_empty_idx = r_chk_idx;
                end
                if (r_cnt == CNT_END) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_DONE;
                n_res   = '0;
                case (r_req.cmd)
                    arpc_pkg::CMD_LOOKUP: begin
                        if (r_found) begin
                            n_res.hit  = 1'b1;
                            n_res.mac  = r_hit_mac;
                            n_res.slot = arpc_pkg::to_slot(r_idx);
                        end
                    end
                    arpc_pkg::CMD_ADD: begin
                        ram_we = 1'b1;
                        if (r_found) begin
                            ram_waddr  = r_idx;
                            n_res.hit  = 1'b1;
                            n_res.slot = arpc_pkg::to_slot(r_idx);
                        end else if (r_empty) begin
                            ram_waddr            = r_empty_idx;
                            n_valid[r_empty_idx] = 1'b1;
                            n_res.slot           = arpc_pkg::to_slot(r_empty_idx);
                        end else begin
                            ram_waddr      = r_ptr;
                            n_valid[r_ptr] = 1'b1;
                            n_res.slot     = arpc_pkg::to_slot(r_ptr);
                            n_res.evicted  = 1'b1;
                            n_ptr = (r_ptr == IDX_LAST) ? '0
                                                        : r_ptr + arpc_pkg::IDX_W'(1);
                        end
                    end
                    arpc_pkg::CMD_DELETE: begin
                        if (r_found) begin
                            n_res.hit  = 1'b1;
                            n_res.slot = arpc_pkg::to_slot(r_idx);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_DONE: begin
                if (i_ctl.res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_chk   <= 1'b0;
            r_valid <= '0;
            r_ptr   <= '0;
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chk   <= n_chk;
            r_valid <= n_valid;
            r_ptr   <= n_ptr;
            r_found <= n_found;
            r_empty <= n_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_chk_idx   <= n_chk_idx;
        r_idx       <= n_idx;
        r_empty_idx <= n_empty_idx;
        r_hit_mac   <= n_hit_mac;
        r_res       <= n_res;
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_res       = r_res;

    a_we_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_WRITE))
        else $error("entry memory written outside write-back");

    a_clear_wipes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_ctl.start && i_req.cmd == arpc_pkg::CMD_CLEAR)
        |=> (r_valid == '0 && r_ptr == '0))
        else $error("clear left valid entries or pointer");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_cnt == CNT_END) |=> (r_state == ST_WRITE))
        else $error("scan did not end in write-back");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && r_req.cmd == arpc_pkg::CMD_ADD && !r_found && !r_empty)
        |-> (r_valid == '1))
        else $error("eviction with an empty slot present");

    a_evict_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_res.evicted) |-> !r_res.hit)
        else $error("result marks both hit and evicted");

endmodule

// File: rtl/arp_cache_fifo_replace.sv
// arp cache top level: stream ports, output register and scan engine
//
// channel   dir  transaction fields
// s_axis    in   tuser: command[1:0]; tdata: ip_address[31:0], mac_address[79:32]
// m_axis    out  tdata: hit[0], mac_result[48:1], slot[52:49], evicted[53]
//
// lookup, add and delete scan all entries, one entry memory read per cycle,
// and a new request is accepted only once the engine is back in idle
// clear skips the scan; results wait in an output register
// a stalled output holds the engine in its done state and blocks input
// reset clears all valid bits and the replacement pointer at once
module arp_cache_fifo_replace (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [arpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // ip_address, mac_address
    input  logic [arpc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [arpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // hit, mac_result, slot, evicted
);

    arpc_pkg::t_eng_ctl  eng_ctl;
    arpc_pkg::t_eng_stat eng_stat;
    arpc_pkg::t_req      eng_req;
    arpc_pkg::t_res      eng_res;

    logic                r_out_valid, n_out_valid;
    arpc_pkg::t_res      r_out, n_out;
    logic                res_ready;

    assign res_ready         = !r_out_valid || m_axis_tready;
    assign s_axis_tready     = eng_stat.idle;
    assign eng_ctl.start     = s_axis_tvalid && eng_stat.idle;
    assign eng_ctl.res_ready = res_ready;

    assign eng_req.cmd = arpc_pkg::t_cmd'(s_axis_tuser);
    assign eng_req.ip  = s_axis_tdata[arpc_pkg::IP_W-1:0];
    assign eng_req.mac = s_axis_tdata[arpc_pkg::ENTRY_W-1:arpc_pkg::IP_W];

    arpc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_req   (eng_req),
        .o_stat  (eng_stat),
        .o_res   (eng_res)
    );

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        if (eng_stat.done && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = eng_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{arpc_pkg::OUT_PAD_W{1'b0}}, r_out.evicted, r_out.slot,
                            r_out.mac, r_out.hit};

endmodule
